### sv/mdt_pkg.sv
// ----------------------------------------------------------------------------
// mdt_pkg
// Shared types and constants of the multi-slot deadline timer.
// ----------------------------------------------------------------------------
package mdt_pkg;

   localparam int SLOT_COUNT_DEFAULT    = 16;
   localparam int INTERVAL_BITS_DEFAULT = 24;
   localparam int MAX_RESULTS           = 16;

   localparam int MODE_W     = 2;
   localparam int SLOT_ID_W  = 4;
   localparam int TIME_W     = 32;
   localparam int REPEAT_W   = 24;

   localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_START = 2'd1;
   localparam logic [MODE_W-1:0] MODE_STOP  = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0]    mode;
      logic [SLOT_ID_W-1:0] slot_id;
      logic [TIME_W-1:0]    time_value;
      logic                 is_absolute;
      logic                 is_repeating;
      logic [REPEAT_W-1:0]  repeat_interval;
   } req_type;

   typedef struct packed {
      logic [SLOT_ID_W-1:0] expired_slot;
      logic [TIME_W-1:0]    deadline_hit;
      logic                 last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SETTLE,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic insert;
      logic pop;
   } chain_ctl_type;

   typedef struct packed {
      logic write;
      logic arm;
      logic disarm;
   } store_ctl_type;

endpackage

### sv/mdt_req_if.sv
// ----------------------------------------------------------------------------
// mdt_req_if
// Request channel: valid/ready handshake with one command item.
// ----------------------------------------------------------------------------
interface mdt_req_if;
   import mdt_pkg::*;

   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### sv/mdt_rsp_if.sv
// ----------------------------------------------------------------------------
// mdt_rsp_if
// Response channel: valid/ready handshake with one expiry report.
// ----------------------------------------------------------------------------
interface mdt_rsp_if;
   import mdt_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### sv/multi_slot_deadline_timer.sv
// ----------------------------------------------------------------------------
// multi_slot_deadline_timer
// Timer slots sharing one wrapping 32-bit counter; due slots are reported
// earliest deadline first through a sorted chain of cells.
// ----------------------------------------------------------------------------
// Start and stop items are taken while idle. A tick with no armed slot
// reports nothing. Otherwise the tick sweeps the slot store one slot per
// cycle through its single read port, then reports one expiry per cycle
// while the response side is ready, and returns to idle once the chain is
// empty. Due slots are sorted on the fly into a chain of min(SLOT_COUNT, 16)
// cells; at most 16 expiries come out per tick and any further due slots stay
// pending for a later tick. The last report of a tick carries last = 1. No
// new request is taken until a tick is drained.
module multi_slot_deadline_timer #(
   parameter int SLOT_COUNT    = mdt_pkg::SLOT_COUNT_DEFAULT,
   parameter int INTERVAL_BITS = mdt_pkg::INTERVAL_BITS_DEFAULT
) (
   input logic     clock,
   input logic     reset,
   mdt_req_if.sink   req_ch,
   mdt_rsp_if.source rsp_ch
);
   import mdt_pkg::*;

   localparam int IDX_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int DEPTH     = (SLOT_COUNT < MAX_RESULTS) ? SLOT_COUNT : MAX_RESULTS;
   localparam int PAYLOAD_W = 1 + INTERVAL_BITS + 32 + IDX_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

   state_type        state_ff, state_in;
   logic [31:0]      count_ff, count_in;
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic             rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0] rd_idx_ff;

   store_ctl_type            store_ctl;
   logic [IDX_W-1:0]         wr_addr;
   logic [31:0]              wr_deadline;
   logic [INTERVAL_BITS-1:0] wr_interval;
   logic                     wr_repeats;
   logic [31:0]              rd_deadline;
   logic [INTERVAL_BITS-1:0] rd_interval;
   logic                     rd_armed;
   logic                     rd_repeats;
   logic                     any_armed;

   chain_ctl_type        chain_ctl;
   logic [31:0]          new_age;
   logic [31:0]          new_diff;
   logic [PAYLOAD_W-1:0] new_data;
   logic                 new_due;

   logic                 cell_valid  [DEPTH];
   logic [31:0]          cell_age    [DEPTH];
   logic [PAYLOAD_W-1:0] cell_data   [DEPTH];
   logic                 cell_better [DEPTH];

   logic [IDX_W-1:0]         head_slot;
   logic [31:0]              head_deadline;
   logic [INTERVAL_BITS-1:0] head_interval;
   logic                     head_repeats;
   logic                     head_last;
   logic                     slot_in_range;
   logic                     rsp_fire;

   mdt_slot_store #(
      .SLOT_COUNT    (SLOT_COUNT),
      .INTERVAL_BITS (INTERVAL_BITS)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .ctl         (store_ctl),
      .wr_addr     (wr_addr),
      .wr_deadline (wr_deadline),
      .wr_interval (wr_interval),
      .wr_repeats  (wr_repeats),
      .rd_addr     (scan_ff),
      .rd_deadline (rd_deadline),
      .rd_interval (rd_interval),
      .rd_armed    (rd_armed),
      .rd_repeats  (rd_repeats),
      .any_armed   (any_armed)
   );

   // due when the wrapping difference deadline - count is zero or negative
   assign new_diff = rd_deadline - count_ff;
   assign new_age  = count_ff - rd_deadline;
   assign new_due  = rd_armed && ((new_diff == 32'd0) || new_diff[31]);
   assign new_data = {rd_repeats, rd_interval, rd_deadline, rd_idx_ff};
   assign chain_ctl.insert = rd_valid_ff && new_due;

   generate
      for (genvar i = 0; i < DEPTH; i++) begin : g_cell
         logic                 l_better;
         logic                 l_valid;
         logic [31:0]          l_age;
         logic [PAYLOAD_W-1:0] l_data;
         logic                 r_valid;
         logic [31:0]          r_age;
         logic [PAYLOAD_W-1:0] r_data;

         if (i == 0) begin : g_head
            assign l_better = 1'b0;
            assign l_valid  = 1'b0;
            assign l_age    = '0;
            assign l_data   = '0;
         end else begin : g_mid
            assign l_better = cell_better[i-1];
            assign l_valid  = cell_valid[i-1];
            assign l_age    = cell_age[i-1];
            assign l_data   = cell_data[i-1];
         end

         if (i == DEPTH - 1) begin : g_tail
            assign r_valid = 1'b0;
            assign r_age   = '0;
            assign r_data  = '0;
         end else begin : g_body
            assign r_valid = cell_valid[i+1];
            assign r_age   = cell_age[i+1];
            assign r_data  = cell_data[i+1];
         end

         mdt_cell #(
            .PAYLOAD_W (PAYLOAD_W)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (chain_ctl),
            .new_age     (new_age),
            .new_data    (new_data),
            .left_better (l_better),
            .left_valid  (l_valid),
            .left_age    (l_age),
            .left_data   (l_data),
            .right_valid (r_valid),
            .right_age   (r_age),
            .right_data  (r_data),
            .better      (cell_better[i]),
            .valid       (cell_valid[i]),
            .age         (cell_age[i]),
            .data        (cell_data[i])
         );
      end

      if (DEPTH == 1) begin : g_last_single
         assign head_last = 1'b1;
      end else begin : g_last_chain
         assign head_last = !cell_valid[1];
      end
   endgenerate

   assign head_slot     = cell_data[0][IDX_W-1:0];
   assign head_deadline = cell_data[0][IDX_W +: 32];
   assign head_interval = cell_data[0][IDX_W+32 +: INTERVAL_BITS];
   assign head_repeats  = cell_data[0][PAYLOAD_W-1];

   assign slot_in_range = 32'(req_ch.data.slot_id) < SLOT_COUNT;

   assign req_ch.ready              = (state_ff == ST_IDLE);
   assign rsp_ch.valid              = (state_ff == ST_DRAIN) && cell_valid[0];
   assign rsp_ch.data.expired_slot  = SLOT_ID_W'(head_slot);
   assign rsp_ch.data.deadline_hit  = head_deadline;
   assign rsp_ch.data.last          = head_last;
   assign rsp_fire                  = rsp_ch.valid && rsp_ch.ready;
   assign chain_ctl.pop             = rsp_fire;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      scan_in     = scan_ff;
      rd_valid_in = 1'b0;
      store_ctl   = '0;
      wr_addr     = IDX_W'(req_ch.data.slot_id);
      wr_deadline = req_ch.data.is_absolute ? req_ch.data.time_value
                                            : count_ff + req_ch.data.time_value;
      wr_interval = INTERVAL_BITS'(req_ch.data.repeat_interval);
      wr_repeats  = req_ch.data.is_repeating;
      case (state_ff)
         ST_IDLE: begin
            scan_in = '0;
            if (req_ch.valid) begin
               case (req_ch.data.mode)
                  MODE_TICK: begin
                     if (any_armed) begin
                        count_in = count_ff + 32'd1;
                        state_in = ST_SCAN;
                     end
                  end
                  MODE_START: begin
                     store_ctl.write = slot_in_range;
                     store_ctl.arm   = slot_in_range;
                  end
                  MODE_STOP: begin
                     store_ctl.disarm = slot_in_range;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            rd_valid_in = 1'b1;
            scan_in     = scan_ff + IDX_W'(1);
            if (scan_ff == LAST_IDX) begin
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            // last read is inserted into the chain this cycle
            state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            wr_addr     = head_slot;
            wr_deadline = head_deadline + 32'(head_interval);
            wr_interval = head_interval;
            wr_repeats  = head_repeats;
            if (!cell_valid[0]) begin
               state_in = ST_IDLE;
            end else if (rsp_fire) begin
               store_ctl.write  = head_repeats;
               store_ctl.disarm = !head_repeats;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         scan_ff     <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         scan_ff     <= scan_in;
         rd_valid_ff <= rd_valid_in;
      end
      rd_idx_ff <= scan_ff;
   end
endmodule

### sv/mdt_cell.sv
// ----------------------------------------------------------------------------
// mdt_cell
// One cell of the sorted expiry chain. Holds one due slot keyed by its age;
// a larger age sorts toward the head. Inserts shift the tail right, pops
// shift everything left.
// ----------------------------------------------------------------------------
module mdt_cell #(
   parameter int PAYLOAD_W = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mdt_pkg::chain_ctl_type ctl,
   input  logic [31:0]           new_age,
   input  logic [PAYLOAD_W-1:0]  new_data,
   input  logic                  left_better,
   input  logic                  left_valid,
   input  logic [31:0]           left_age,
   input  logic [PAYLOAD_W-1:0]  left_data,
   input  logic                  right_valid,
   input  logic [31:0]           right_age,
   input  logic [PAYLOAD_W-1:0]  right_data,
   output logic                  better,
   output logic                  valid,
   output logic [31:0]           age,
   output logic [PAYLOAD_W-1:0]  data
);
   import mdt_pkg::*;

   logic                 valid_ff, valid_in;
   logic [31:0]          age_ff, age_in;
   logic [PAYLOAD_W-1:0] data_ff, data_in;

   // strict compare keeps equal ages in scan order (lower slot first)
   assign better = ctl.insert && (!valid_ff || (new_age > age_ff));

   always_comb begin
      valid_in = valid_ff;
      age_in   = age_ff;
      data_in  = data_ff;
      if (ctl.pop) begin
         valid_in = right_valid;
         age_in   = right_age;
         data_in  = right_data;
      end else if (better) begin
         if (left_better) begin
            valid_in = left_valid;
            age_in   = left_age;
            data_in  = left_data;
         end else begin
            valid_in = 1'b1;
            age_in   = new_age;
            data_in  = new_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      age_ff  <= age_in;
      data_ff <= data_in;
   end

   assign valid = valid_ff;
   assign age   = age_ff;
   assign data  = data_ff;
endmodule

### sv/mdt_slot_store.sv
// ----------------------------------------------------------------------------
// mdt_slot_store
// Per-slot settings: deadline and interval memories with registered read,
// armed and repeat flags in flops.
// ----------------------------------------------------------------------------
module mdt_slot_store #(
   parameter int SLOT_COUNT    = 16,
   parameter int INTERVAL_BITS = 24,
   localparam int IDX_W        = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  mdt_pkg::store_ctl_type    ctl,
   input  logic [IDX_W-1:0]          wr_addr,
   input  logic [31:0]               wr_deadline,
   input  logic [INTERVAL_BITS-1:0]  wr_interval,
   input  logic                      wr_repeats,
   input  logic [IDX_W-1:0]          rd_addr,
   output logic [31:0]               rd_deadline,
   output logic [INTERVAL_BITS-1:0]  rd_interval,
   output logic                      rd_armed,
   output logic                      rd_repeats,
   output logic                      any_armed
);
   import mdt_pkg::*;

   logic [31:0]              deadline_mem [SLOT_COUNT];
   logic [INTERVAL_BITS-1:0] interval_mem [SLOT_COUNT];
   logic [SLOT_COUNT-1:0]    armed_ff;
   logic [SLOT_COUNT-1:0]    repeats_ff;
   logic [31:0]              rd_deadline_ff;
   logic [INTERVAL_BITS-1:0] rd_interval_ff;
   logic                     rd_armed_ff;
   logic                     rd_repeats_ff;

   always_ff @(posedge clock) begin
      if (ctl.write) begin
         deadline_mem[wr_addr] <= wr_deadline;
         interval_mem[wr_addr] <= wr_interval;
      end
      rd_deadline_ff <= deadline_mem[rd_addr];
      rd_interval_ff <= interval_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff    <= '0;
         repeats_ff  <= '0;
         rd_armed_ff <= 1'b0;
      end else begin
         if (ctl.write) begin
            repeats_ff[wr_addr] <= wr_repeats;
         end
         if (ctl.arm) begin
            armed_ff[wr_addr] <= 1'b1;
         end else if (ctl.disarm) begin
            armed_ff[wr_addr] <= 1'b0;
         end
         rd_armed_ff <= armed_ff[rd_addr];
      end
      rd_repeats_ff <= repeats_ff[rd_addr];
   end

   assign rd_deadline = rd_deadline_ff;
   assign rd_interval = rd_interval_ff;
   assign rd_armed    = rd_armed_ff;
   assign rd_repeats  = rd_repeats_ff;
   assign any_armed   = |armed_ff;
endmodule
